>>> design/prh_pkg.sv
// shared constants and types for the hourly rain accumulation block
`default_nettype none

package prh_pkg;

    // grid geometry
    localparam int unsigned NUM_AZIMUTHS   = 360;
    localparam int unsigned NUM_RANGE_BINS = 115;
    localparam int unsigned GRID_DEPTH     = NUM_AZIMUTHS * NUM_RANGE_BINS;
    localparam int unsigned GRID_AW        = $clog2(GRID_DEPTH);

    // scaling constants
    localparam int unsigned WEIGHT_SCALE  = 1000;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned CELL_MAX      = 32767;
    localparam int unsigned POSS_MAX      = 65535;

    // constant division: strip a power of two, then divide by the odd part
    localparam int unsigned HOUR_SHIFT = 4;
    localparam int unsigned HOUR_DIV   = SECS_PER_HOUR >> HOUR_SHIFT;
    localparam int unsigned PER_SHIFT  = 3;
    localparam int unsigned PER_DIV    = WEIGHT_SCALE >> PER_SHIFT;

    localparam int unsigned NUM_W   = 32;
    localparam int unsigned M_W     = NUM_W - HOUR_SHIFT;
    localparam int unsigned RECIP_W = 26;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned Q_W     = M_W + RECIP_W - RECIP_SHIFT;
    localparam int unsigned REM_W   = 9;

    localparam logic [RECIP_W-1:0] RECIP_HOUR =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(HOUR_DIV));
    localparam logic [RECIP_W-1:0] RECIP_PER =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(PER_DIV));

    // reset values
    localparam logic [14:0] MAX_HOUR_TOTAL_RST = 15'd16000;
    localparam logic [9:0]  WEIGHT_RST         = 10'd1000;

    // configuration register indexes
    localparam logic CFG_MAX_RAIN_RATE  = 1'b0;
    localparam logic CFG_MAX_HOUR_TOTAL = 1'b1;

    typedef enum logic [1:0] {
        CMD_NEW_HOUR   = 2'd0,
        CMD_BEGIN_SCAN = 2'd1,
        CMD_ACCUM_BIN  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_CLAMP = 2'd2
    } mode_t;

endpackage

`default_nettype wire

>>> design/polar_rain_hourly_accumulate.sv
// top level: hourly rain accumulation over a polar grid
//
// usage
//   input channel s_*: one command item per handshake (new hour, begin scan,
//   accumulate bin). output channel m_*: exactly one result item per input
//   item, in order. configuration: cfg_we / cfg_index / cfg_wdata, written
//   only while the block is idle.
// timing
//   a lockstep five-stage pipeline: operand select, multiply, reciprocal
//   multiply, remainder, grid update. items pass the s1 to s4 registers
//   into the output register. one item per cycle is sustained while the
//   output does not stall, limited by the single read-modify-write of the
//   grid memory per bin; back-to-back same-cell bins bypass the memory.
// stalls
//   while a result waits in the output register and m_ready is low the whole
//   pipeline holds and s_ready is low; it resumes in the cycle m_ready rises.
// reset
//   clears the pipeline, arms copy mode, zeroes the possible total and
//   restores the register defaults. the grid memory is not cleared: the
//   first scan of an hour runs in copy mode; its bins overwrite their cells.
`default_nettype none

module polar_rain_hourly_accumulate
    import prh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,

    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [9:0]  s_weight_thousandths,
    input  wire logic [15:0] s_interval_seconds,
    input  wire logic [14:0] s_period_value,
    input  wire logic [8:0]  s_azimuth,
    input  wire logic [6:0]  s_range_bin,

    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [14:0]      m_cell_total,
    output logic [15:0]      m_max_possible,
    output logic [1:0]       m_scan_mode
);

    // configuration registers
    logic [15:0] max_rain_rate_reg;
    logic [14:0] max_hour_total_reg;

    // block state
    logic        copy_pending_reg, copy_pending_next;
    logic [15:0] possible_total_reg, possible_total_next;
    logic [9:0]  latched_weight_reg;
    mode_t       latched_mode_reg, latched_mode_next;

    // pipeline control
    logic advance;
    logic accept;
    logic commit;

    // stage 1: multiply operands
    logic               s1_valid_reg;
    logic [1:0]         s1_cmd_reg;
    logic               s1_addr_ok_reg;
    logic [GRID_AW-1:0] s1_addr_reg;
    logic [15:0]        s1_opa_reg, s1_opb_reg;

    // stage 2: rounded numerator
    logic               s2_valid_reg;
    logic [1:0]         s2_cmd_reg;
    logic               s2_addr_ok_reg;
    logic [GRID_AW-1:0] s2_addr_reg;
    logic [NUM_W-1:0]   s2_num_reg;

    // stage 3: quotient estimate, grid read issued
    logic               s3_valid_reg;
    logic [1:0]         s3_cmd_reg;
    logic               s3_addr_ok_reg;
    logic [GRID_AW-1:0] s3_addr_reg;
    logic [M_W-1:0]     s3_m_reg;
    logic [Q_W-1:0]     s3_qest_reg;

    // stage 4: correction and grid update
    logic               s4_valid_reg;
    logic [1:0]         s4_cmd_reg;
    logic               s4_addr_ok_reg;
    logic [GRID_AW-1:0] s4_addr_reg;
    logic [Q_W-1:0]     s4_qest_reg;
    logic [REM_W-1:0]   s4_rem_reg;

    // output register
    logic        m_valid_reg;
    logic [14:0] cell_total_reg;
    logic [15:0] max_possible_reg;
    logic [1:0]  scan_mode_reg;

    // forwarding of a write that collided with the read of the next item
    logic        fwd_hit_reg;
    logic [14:0] fwd_data_reg;

    // combinational
    logic [GRID_AW-1:0]         in_addr;
    logic                       in_addr_ok;
    logic [15:0]                in_opa, in_opb;
    logic [NUM_W-1:0]           s1_prod;
    logic [NUM_W-1:0]           s1_num;
    logic [M_W-1:0]             s2_m;
    logic [RECIP_W-1:0]         s2_recip;
    logic [M_W+RECIP_W-1:0]     s2_prod;
    logic [REM_W-1:0]           s3_div;
    logic [Q_W+REM_W-1:0]       s3_qd;
    logic [M_W-1:0]             s3_rem_full;
    logic [REM_W-1:0]           s4_div;
    logic [Q_W:0]               q_fix;
    logic [Q_W:0]               scan_sum;
    logic [Q_W:0]               cell_sum;
    logic [14:0]                old_cell;
    logic [14:0]                ram_rdata;
    logic [14:0]                cell_new;
    logic                       ram_we;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign commit  = advance && s4_valid_reg;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rain_rate_reg  <= '0;
            max_hour_total_reg <= MAX_HOUR_TOTAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_RAIN_RATE:  max_rain_rate_reg  <= cfg_wdata;
                CFG_MAX_HOUR_TOTAL: max_hour_total_reg <= cfg_wdata[14:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // accept: address, operand select, weight latch
    // ---------------------------------------------------------------
    assign in_addr = GRID_AW'(s_azimuth) * GRID_AW'(NUM_RANGE_BINS) + GRID_AW'(s_range_bin);
    assign in_addr_ok = (32'(s_azimuth) < NUM_AZIMUTHS) && (32'(s_range_bin) < NUM_RANGE_BINS);

    // begin scan: rate * interval; bin: value * weight
    always_comb begin
        in_opa = '0;
        in_opb = '0;
        case (s_command)
            CMD_BEGIN_SCAN: begin
                in_opa = max_rain_rate_reg;
                in_opb = s_interval_seconds;
            end
            CMD_ACCUM_BIN: begin
                in_opa = {1'b0, s_period_value};
                in_opb = {6'b0, latched_weight_reg};
            end
            default: ;
        endcase
    end

    // weight is latched at accept so that later bins pick it up at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_weight_reg <= WEIGHT_RST;
        end else if (accept && s_command == CMD_BEGIN_SCAN) begin
            latched_weight_reg <= s_weight_thousandths;
        end
    end

    // ---------------------------------------------------------------
    // arithmetic stages
    // ---------------------------------------------------------------
    // product plus half divisor for round half away from zero
    assign s1_prod = NUM_W'(s1_opa_reg) * NUM_W'(s1_opb_reg);
    assign s1_num  = s1_prod + ((s1_cmd_reg == CMD_BEGIN_SCAN) ?
                                NUM_W'(SECS_PER_HOUR / 2) : NUM_W'(WEIGHT_SCALE / 2));

    // floor(n / (2^k * d)) = floor(floor(n / 2^k) / d), d by reciprocal
    assign s2_m     = (s2_cmd_reg == CMD_BEGIN_SCAN) ? M_W'(s2_num_reg >> HOUR_SHIFT)
                                                     : M_W'(s2_num_reg >> PER_SHIFT);
    assign s2_recip = (s2_cmd_reg == CMD_BEGIN_SCAN) ? RECIP_HOUR : RECIP_PER;
    assign s2_prod  = (M_W+RECIP_W)'(s2_m) * (M_W+RECIP_W)'(s2_recip);

    // estimate is exact or one low; remainder is below twice the divisor
    assign s3_div      = (s3_cmd_reg == CMD_BEGIN_SCAN) ? REM_W'(HOUR_DIV) : REM_W'(PER_DIV);
    assign s3_qd       = (Q_W+REM_W)'(s3_qest_reg) * (Q_W+REM_W)'(s3_div);
    assign s3_rem_full = s3_m_reg - s3_qd[M_W-1:0];

    assign s4_div = (s4_cmd_reg == CMD_BEGIN_SCAN) ? REM_W'(HOUR_DIV) : REM_W'(PER_DIV);
    assign q_fix  = {1'b0, s4_qest_reg} + (Q_W+1)'(s4_rem_reg >= s4_div);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cmd_reg     <= s_command;
            s1_addr_ok_reg <= in_addr_ok;
            s1_addr_reg    <= in_addr;
            s1_opa_reg     <= in_opa;
            s1_opb_reg     <= in_opb;

            s2_cmd_reg     <= s1_cmd_reg;
            s2_addr_ok_reg <= s1_addr_ok_reg;
            s2_addr_reg    <= s1_addr_reg;
            s2_num_reg     <= s1_num;

            s3_cmd_reg     <= s2_cmd_reg;
            s3_addr_ok_reg <= s2_addr_ok_reg;
            s3_addr_reg    <= s2_addr_reg;
            s3_m_reg       <= s2_m;
            s3_qest_reg    <= s2_prod[M_W+RECIP_W-1:RECIP_SHIFT];

            s4_cmd_reg     <= s3_cmd_reg;
            s4_addr_ok_reg <= s3_addr_ok_reg;
            s4_addr_reg    <= s3_addr_reg;
            s4_qest_reg    <= s3_qest_reg;
            s4_rem_reg     <= s3_rem_full[REM_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // grid memory: read at stage 3, write back at stage 4
    // ---------------------------------------------------------------
    prh_ram #(
        .WIDTH (15),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s4_addr_reg),
        .wdata (cell_new),
        .re    (advance),
        .raddr (s3_addr_reg),
        .rdata (ram_rdata)
    );

    // the memory returns old data on a same-cycle write, so take the bypass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (advance) begin
            fwd_hit_reg <= ram_we && s3_valid_reg && (s4_addr_reg == s3_addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fwd_data_reg <= cell_new;
        end
    end

    assign old_cell = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    // ---------------------------------------------------------------
    // stage 4: state update and cell result
    // ---------------------------------------------------------------
    assign scan_sum = (Q_W+1)'(possible_total_reg) + q_fix;
    assign cell_sum = ((latched_mode_reg == MODE_COPY) ? '0 : (Q_W+1)'(old_cell)) + q_fix;

    always_comb begin
        copy_pending_next   = copy_pending_reg;
        possible_total_next = possible_total_reg;
        latched_mode_next   = latched_mode_reg;
        cell_new            = '0;
        ram_we              = 1'b0;
        case (s4_cmd_reg)
            CMD_NEW_HOUR: begin
                copy_pending_next   = 1'b1;
                possible_total_next = '0;
            end
            CMD_BEGIN_SCAN: begin
                if (copy_pending_reg) begin
                    latched_mode_next = MODE_COPY;
                    copy_pending_next = 1'b0;
                end else if (scan_sum <= (Q_W+1)'(max_hour_total_reg)) begin
                    latched_mode_next = MODE_ADD;
                end else begin
                    latched_mode_next = MODE_CLAMP;
                end
                possible_total_next = (scan_sum > (Q_W+1)'(POSS_MAX)) ?
                                      16'(POSS_MAX) : scan_sum[15:0];
            end
            CMD_ACCUM_BIN: begin
                if (s4_addr_ok_reg) begin
                    if (latched_mode_reg == MODE_CLAMP) begin
                        cell_new = (cell_sum > (Q_W+1)'(max_hour_total_reg)) ?
                                   max_hour_total_reg : cell_sum[14:0];
                    end else begin
                        cell_new = (cell_sum > (Q_W+1)'(CELL_MAX)) ?
                                   15'(CELL_MAX) : cell_sum[14:0];
                    end
                    ram_we = commit;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_pending_reg   <= 1'b1;
            possible_total_reg <= '0;
            latched_mode_reg   <= MODE_COPY;
        end else if (commit) begin
            copy_pending_reg   <= copy_pending_next;
            possible_total_reg <= possible_total_next;
            latched_mode_reg   <= latched_mode_next;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cell_total_reg   <= cell_new;
            max_possible_reg <= possible_total_next;
            scan_mode_reg    <= latched_mode_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_total   = cell_total_reg;
    assign m_max_possible = max_possible_reg;
    assign m_scan_mode    = scan_mode_reg;

`ifndef NO_ASSERTIONS
    // a bypass hit only follows a real write to the grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fwd_hit_reg) |-> $past(ram_we))
        else $error("bypass hit without a grid write");

    // clamped cells never exceed the hourly ceiling
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && scan_mode_reg == MODE_CLAMP |-> cell_total_reg <= max_hour_total_reg)
        else $error("clamped cell above hourly ceiling");

    // only a new hour lowers the possible total
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit && s4_cmd_reg != CMD_NEW_HOUR |=> possible_total_reg >= $past(possible_total_reg))
        else $error("possible total decreased without new hour");

    // grid writes stay inside the grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> 32'(s4_addr_reg) < GRID_DEPTH)
        else $error("grid write out of range");
`endif

endmodule

`default_nettype wire

>>> design/prh_ram.sv
// generic simple dual port ram with registered read, read-first
`default_nettype none

module prh_ram #(
    parameter int unsigned WIDTH = 15,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> bench/polar_rain_hourly_accumulate_tb.sv
// testbench for the hourly polar rain accumulation block
`timescale 1ns / 100ps

module polar_rain_hourly_accumulate_tb;
    import prh_pkg::*;

    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned PIPE_DEPTH      = 4;       // item accepted to result registered
    localparam int unsigned ITEMS_PER_PHASE = 575;     // three idling phases
    localparam int unsigned CYCLE_LIMIT     = 400000;  // many times the slowest legal run
    localparam logic [1:0]  CMD_UNUSED      = 2'd3;    // the one command code with no meaning

    // one result item as the block should report it
    typedef struct packed {
        logic [14:0] cell_total;
        logic [15:0] max_possible;
        mode_t       scan_mode;
    } hour_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration port
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_MAX_RAIN_RATE;
    logic [15:0] cfg_wdata = '0;

    // input channel
    logic        s_valid              = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command            = '0;
    logic [9:0]  s_weight_thousandths = '0;
    logic [15:0] s_interval_seconds   = '0;
    logic [14:0] s_period_value       = '0;
    logic [8:0]  s_azimuth            = '0;
    logic [6:0]  s_range_bin          = '0;

    // result channel
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [14:0] m_cell_total;
    logic [15:0] m_max_possible;
    logic [1:0]  m_scan_mode;

    // our own view of the block: grid, hour bookkeeping and limits
    logic [14:0]  grid_cells [GRID_DEPTH];
    bit           grid_written [GRID_DEPTH];
    int unsigned  written_cells [$];       // cells that an add-mode bin may safely revisit
    int unsigned  last_cell;
    bit           have_last    = 1'b0;
    bit           copy_armed   = 1'b1;
    logic [15:0]  possible_sum = '0;
    logic [9:0]   scan_weight  = WEIGHT_RST;
    mode_t        scan_mode_q  = MODE_COPY;
    logic [15:0]  max_rate_reg = '0;
    logic [14:0]  max_hour_reg = MAX_HOUR_TOTAL_RST;

    // results still owed by the block, oldest first
    hour_result_t awaited_results [$];

    int unsigned  items_sent     = 0;
    int unsigned  fail_count     = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  src_gap_pct    = 0;
    int unsigned  sink_stall_pct = 0;

    polar_rain_hourly_accumulate u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_weight_thousandths (s_weight_thousandths),
        .s_interval_seconds   (s_interval_seconds),
        .s_period_value       (s_period_value),
        .s_azimuth            (s_azimuth),
        .s_range_bin          (s_range_bin),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_cell_total         (m_cell_total),
        .m_max_possible       (m_max_possible),
        .m_scan_mode          (m_scan_mode)
    );

    // 20 ns clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // run the hour bookkeeping and the grid forward by one item
    function automatic hour_result_t step_hour_grid(
        input logic [1:0]  cmd,
        input logic [9:0]  wt,
        input logic [15:0] secs,
        input logic [14:0] val,
        input logic [8:0]  az,
        input logic [6:0]  rb
    );
        hour_result_t    res;
        longint unsigned oflow;
        longint unsigned sum;
        longint unsigned old;
        longint unsigned acc;
        int unsigned     cell_ix;
        res.cell_total = '0;
        case (cmd)
            CMD_NEW_HOUR: begin
                copy_armed   = 1'b1;
                possible_sum = '0;
            end
            CMD_BEGIN_SCAN: begin
                // worst-case rain over the interval, rounded to the nearest unit
                oflow = (64'(max_rate_reg) * 64'(secs) + 64'(SECS_PER_HOUR / 2))
                        / 64'(SECS_PER_HOUR);
                sum   = 64'(possible_sum) + oflow;
                scan_weight = wt;
                if (copy_armed) begin
                    scan_mode_q = MODE_COPY;
                    copy_armed  = 1'b0;
                end else if (sum <= 64'(max_hour_reg)) begin
                    scan_mode_q = MODE_ADD;
                end else begin
                    scan_mode_q = MODE_CLAMP;
                end
                possible_sum = (sum > 64'(POSS_MAX)) ? 16'(POSS_MAX) : sum[15:0];
            end
            CMD_ACCUM_BIN: begin
                if (az < NUM_AZIMUTHS && rb < NUM_RANGE_BINS) begin
                    cell_ix = az * NUM_RANGE_BINS + rb;
                    old = (scan_mode_q == MODE_COPY) ? 64'd0 : 64'(grid_cells[cell_ix]);
                    // old plus weighted value, half rounded up since all terms are positive
                    acc = (old * 64'(WEIGHT_SCALE) + 64'(val) * 64'(scan_weight)
                           + 64'(WEIGHT_SCALE / 2)) / 64'(WEIGHT_SCALE);
                    if (scan_mode_q == MODE_CLAMP) begin
                        if (acc > 64'(max_hour_reg))
                            acc = 64'(max_hour_reg);
                    end else if (acc > 64'(CELL_MAX)) begin
                        acc = 64'(CELL_MAX);
                    end
                    res.cell_total      = acc[14:0];
                    grid_cells[cell_ix] = acc[14:0];
                    if (!grid_written[cell_ix]) begin
                        grid_written[cell_ix] = 1'b1;
                        written_cells.push_back(cell_ix);
                    end
                    last_cell = cell_ix;
                    have_last = 1'b1;
                end
            end
            default: ;
        endcase
        res.max_possible = possible_sum;
        res.scan_mode    = scan_mode_q;
        return res;
    endfunction

    // offer one item, idling first at the current rate; valid stays up on return
    task automatic send_rain_item(
        input logic [1:0]  cmd,
        input logic [9:0]  wt,
        input logic [15:0] secs,
        input logic [14:0] val,
        input logic [8:0]  az,
        input logic [6:0]  rb
    );
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        // order is fixed from here on, so the expectation can be queued now
        awaited_results.push_back(step_hour_grid(cmd, wt, secs, val, az, rb));
        s_valid              <= 1'b1;
        s_command            <= cmd;
        s_weight_thousandths <= wt;
        s_interval_seconds   <= secs;
        s_period_value       <= val;
        s_azimuth            <= az;
        s_range_bin          <= rb;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        items_sent++;
    endtask

    // hold the sender until every owed result is back and the pipe is empty
    task automatic wait_for_results_drained();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    // write both limits on back-to-back edges; only called with the block idle
    task automatic load_limits(input logic [15:0] rate, input logic [14:0] hour_cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_RAIN_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_index <= CFG_MAX_HOUR_TOTAL;
        cfg_wdata <= 16'(hour_cap);
        @(posedge aclk);
        cfg_we <= 1'b0;
        max_rate_reg = rate;
        max_hour_reg = hour_cap;
    endtask

    // reset defaults: copy before any scan, copy scan, unclamped saturation, unused command
    task automatic test_copy_and_saturation();
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'h7FFF, 9'd0, 7'd0);
        send_rain_item(CMD_UNUSED, 10'h3FF, 16'hFFFF, 15'h7FFF, 9'h1FF, 7'h7F);
        send_rain_item(CMD_BEGIN_SCAN, 10'd1023, 16'hFFFF, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'h7FFF, 9'd359, 7'd114);
        send_rain_item(CMD_BEGIN_SCAN, 10'd500, 16'd0, 15'd0, 9'd0, 7'd0);
        // add on a full cell: just over the top, must stick at the ceiling
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd1, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd0, 9'd0, 7'd0);
    endtask

    // largest rate with a zero hour ceiling, then addresses off the grid
    task automatic test_clamp_and_address();
        wait_for_results_drained();
        load_limits(16'hFFFF, 15'd0);
        send_rain_item(CMD_NEW_HOUR, 10'd0, 16'd0, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_BEGIN_SCAN, 10'd1000, 16'd3600, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd12345, 9'd100, 7'd50);
        // possible total saturates and passes the ceiling: clamped mode
        send_rain_item(CMD_BEGIN_SCAN, 10'd1, 16'd1, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'h7FFF, 9'd100, 7'd50);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd500, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd77, 9'(NUM_AZIMUTHS), 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd77, 9'd0, 7'(NUM_RANGE_BINS));
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd77, 9'h1FF, 7'h7F);
    endtask

    // zero rate with the highest ceiling; zero weight and exact half rounding
    task automatic test_half_rounding();
        wait_for_results_drained();
        load_limits(16'd0, 15'h7FFF);
        send_rain_item(CMD_NEW_HOUR, 10'd0, 16'd0, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_BEGIN_SCAN, 10'd0, 16'hFFFF, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'h7FFF, 9'd1, 7'd1);
        send_rain_item(CMD_BEGIN_SCAN, 10'd999, 16'd1800, 15'd0, 9'd0, 7'd0);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd1, 9'd1, 7'd1);
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd1, 9'd1, 7'd1);
        send_rain_item(CMD_BEGIN_SCAN, 10'd500, 16'd7, 15'd0, 9'd0, 7'd0);
        // 2 + 0.5 must go up to 3
        send_rain_item(CMD_ACCUM_BIN, 10'd0, 16'd0, 15'd1, 9'd1, 7'd1);
    endtask

    // random hours: new hour, a few scans, bins on them, with some noise mixed in
    task automatic run_random_hours(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned n_scans;
        int unsigned n_bins;
        int unsigned pick;
        int unsigned cell_ix;
        logic [9:0]  wt;
        logic [15:0] secs;
        logic [14:0] val;
        logic [8:0]  az;
        logic [6:0]  rb;
        logic [15:0] rate;
        logic [14:0] cap;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            // now and then let the pipe run dry and move the limits
            if ($urandom_range(3) == 0) begin
                wait_for_results_drained();
                case ($urandom_range(3))
                    0:       rate = 16'd0;
                    1:       rate = 16'hFFFF;
                    default: rate = 16'($urandom_range(0, 4000));
                endcase
                case ($urandom_range(3))
                    0:       cap = 15'd0;
                    1:       cap = 15'h7FFF;
                    2:       cap = 15'($urandom_range(0, 3000));
                    default: cap = 15'($urandom);
                endcase
                load_limits(rate, cap);
            end
            // mostly a fresh hour, sometimes the scans just carry on
            if ($urandom_range(9) != 0)
                send_rain_item(CMD_NEW_HOUR, 10'($urandom), 16'($urandom), 15'($urandom),
                               9'($urandom), 7'($urandom));
            n_scans = $urandom_range(1, 6);
            repeat (n_scans) begin
                pick = $urandom_range(99);
                wt = (pick < 10) ? 10'($urandom_range(1001, 1023)) :
                     (pick < 20) ? 10'd1000 : 10'($urandom_range(0, 1000));
                pick = $urandom_range(99);
                secs = (pick < 10) ? 16'd0 :
                       (pick < 40) ? 16'($urandom) : 16'($urandom_range(0, 900));
                send_rain_item(CMD_BEGIN_SCAN, wt, secs, 15'($urandom), 9'($urandom),
                               7'($urandom));
                n_bins = $urandom_range(1, 12);
                repeat (n_bins) begin
                    pick = $urandom_range(99);
                    if (pick < 6 || (scan_mode_q != MODE_COPY && written_cells.size() == 0)) begin
                        // off the grid on one axis or the other
                        if ($urandom_range(1) == 0) begin
                            az = 9'($urandom_range(NUM_AZIMUTHS, 511));
                            rb = 7'($urandom);
                        end else begin
                            az = 9'($urandom);
                            rb = 7'($urandom_range(NUM_RANGE_BINS, 127));
                        end
                    end else begin
                        // add modes only touch cells already written this run
                        if (pick < 26 && have_last)
                            cell_ix = last_cell;
                        else if (written_cells.size() != 0
                                 && (scan_mode_q != MODE_COPY || pick < 60))
                            cell_ix = written_cells[$urandom_range(0, written_cells.size() - 1)];
                        else if (pick < 80)
                            cell_ix = $urandom_range(0, 3) * NUM_RANGE_BINS + $urandom_range(0, 7);
                        else
                            cell_ix = $urandom_range(0, GRID_DEPTH - 1);
                        az = 9'(cell_ix / NUM_RANGE_BINS);
                        rb = 7'(cell_ix % NUM_RANGE_BINS);
                    end
                    pick = $urandom_range(99);
                    val = (pick < 5)  ? 15'h7FFF :
                          (pick < 30) ? 15'($urandom) : 15'($urandom_range(0, 600));
                    send_rain_item(CMD_ACCUM_BIN, 10'($urandom), 16'($urandom), val, az, rb);
                end
                if ($urandom_range(15) == 0)
                    send_rain_item(CMD_UNUSED, 10'($urandom), 16'($urandom), 15'($urandom),
                                   9'($urandom), 7'($urandom));
            end
        end
    endtask

    // result side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // compare each accepted result with the oldest one owed
    always @(posedge aclk) begin : check_results
        hour_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("result item with nothing owed: cell_total %0d max_possible %0d",
                       m_cell_total, m_max_possible);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_cell_total !== want.cell_total) begin
                    $error("cell_total: expected %0d, got %0d", want.cell_total, m_cell_total);
                    fail_count++;
                end
                if (m_max_possible !== want.max_possible) begin
                    $error("max_possible: expected %0d, got %0d",
                           want.max_possible, m_max_possible);
                    fail_count++;
                end
                if (m_scan_mode !== want.scan_mode) begin
                    $error("scan_mode: expected %0d, got %0d", want.scan_mode, m_scan_mode);
                    fail_count++;
                end
            end
        end
    end

    // hard stop if the run hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        // reset held for a fixed number of edges, released once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender rarely idle, receiver often stalled
        src_gap_pct    = 25;
        sink_stall_pct = 68;
        test_copy_and_saturation();
        test_clamp_and_address();
        test_half_rounding();
        run_random_hours(ITEMS_PER_PHASE);

        // sender often idle, receiver rarely stalled
        src_gap_pct    = 68;
        sink_stall_pct = 25;
        run_random_hours(ITEMS_PER_PHASE);

        // full throughput on both sides
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        run_random_hours(ITEMS_PER_PHASE);

        // let everything owed come back, then watch a little longer for strays
        wait_for_results_drained();
        repeat (4 * PIPE_DEPTH) @(posedge aclk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
